>>> sv/dctg_pkg.sv
// ----------------------------------------------------------------------------
// dctg_pkg
// Shared constants, register indexes and transfer types of the decaying
// chirp tone generator.
// ----------------------------------------------------------------------------
package dctg_pkg;

  // default sizes
  localparam int DEF_SINE_TABLE_DEPTH = 1024;
  localparam int DEF_PHASE_BITS       = 32;
  localparam int DEF_COUNT_BITS       = 24;

  // configuration port
  localparam int CFG_DATA_W = 33;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_STEP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHIRP_START = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHIRP_DECAY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ENV_START   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ENV_DECAY   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_SPAN  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 3'd6;

  // register values after reset
  localparam logic [31:0] RST_BASE_STEP   = 32'd1403337614;
  localparam logic [31:0] RST_CHIRP_START = 32'd0;
  localparam logic [32:0] RST_CHIRP_DECAY = 33'd4294583836;
  localparam logic [14:0] RST_ENV_START   = 15'd16384;
  localparam logic [32:0] RST_ENV_DECAY   = 33'd4294835145;
  localparam logic [15:0] RST_NOISE_SPAN  = 16'd0;
  localparam logic [23:0] RST_POINT_COUNT = 24'd100000;

  // arithmetic constants
  localparam logic [32:0] ONE_Q32     = 33'h1_0000_0000;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [31:0] LFSR_MASK   = 32'h8020_0003;
  localparam logic [31:0] LFSR_SEED   = 32'h1234_5678;

  // per-sample values handed from the state loop to the sample pipeline
  typedef struct packed {
    logic        last;
    logic [47:0] envelope;
    logic [15:0] noise_u;
  } dctg_item_t;

  // finished sample
  typedef struct packed {
    logic        last;
    logic [15:0] sample;
  } dctg_res_t;

endpackage

>>> sv/dctg_state.sv
// ----------------------------------------------------------------------------
// dctg_state
// Time-zero restart, stop check and the per-sample recurrences: phase
// accumulator, chirp step decay, envelope decay, sample count and noise LFSR.
// ----------------------------------------------------------------------------
module dctg_state import dctg_pkg::*; #(
  parameter int PHASE_BITS = DEF_PHASE_BITS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  acc,
  input  logic                  restart,
  input  logic [31:0]           base_step,
  input  logic [31:0]           chirp_start,
  input  logic [32:0]           chirp_f,
  input  logic [14:0]           env_start,
  input  logic [32:0]           env_f,
  input  logic [23:0]           point_count,
  output logic                  produce,
  output logic [PHASE_BITS-1:0] phase,
  output dctg_item_t            item
);

  localparam int LIM_W = (COUNT_BITS > 24) ? COUNT_BITS : 24;

  logic [PHASE_BITS-1:0] phase_r, phase_eff, phase_nxt;
  logic [31:0]           chirp_r, chirp_eff, chirp_nxt;
  logic [47:0]           env_r, env_eff, env_nxt;
  logic [COUNT_BITS-1:0] done_r, done_eff, done_nxt;
  logic [31:0]           lfsr_r, lfsr_nxt;

  logic [LIM_W-1:0]      pc_ext, cmax_ext, limit_ext;
  logic [COUNT_BITS-1:0] limit;
  logic [31:0]           step;
  logic                  cneg;
  logic [31:0]           cabs, cmag;
  logic [64:0]           cprod;
  logic [48:0]           hi_p, env_sum;
  logic [64:0]           lo_p;

  // sixteen galois steps, all xor so it flattens to a shallow network
  function automatic logic [31:0] lfsr16(input logic [31:0] s);
    logic [31:0] v;
    v = s;
    for (int k = 0; k < 16; k++) begin
      v = v[0] ? ((v >> 1) ^ LFSR_MASK) : (v >> 1);
    end
    return v;
  endfunction

  // restart selects time zero ahead of everything else
  always_comb begin
    phase_eff = restart ? '0 : phase_r;
    chirp_eff = restart ? chirp_start : chirp_r;
    env_eff   = restart ? {1'b0, env_start, 32'd0} : env_r;
    done_eff  = restart ? '0 : done_r;
  end

  // sample limit, capped at the counter range
  always_comb begin
    pc_ext    = LIM_W'(point_count);
    cmax_ext  = LIM_W'({COUNT_BITS{1'b1}});
    limit_ext = (pc_ext < cmax_ext) ? pc_ext : cmax_ext;
    limit     = limit_ext[COUNT_BITS-1:0];
    produce   = done_eff < limit;
    done_nxt  = done_eff + 1'b1;
  end

  // phase advance by base plus chirp, top bits of a 32-bit turn
  always_comb begin
    step      = base_step + chirp_eff;
    phase_nxt = phase_eff + step[31 -: PHASE_BITS];
  end

  // chirp decay on the magnitude, so it truncates toward zero
  always_comb begin
    cneg      = chirp_eff[31];
    cabs      = cneg ? (32'd0 - chirp_eff) : chirp_eff;
    cprod     = {33'd0, cabs} * {32'd0, chirp_f};
    cmag      = cprod[63:32];
    chirp_nxt = cneg ? (32'd0 - cmag) : cmag;
  end

  // envelope decay, split into upper and lower halves
  always_comb begin
    hi_p    = {33'd0, env_eff[47:32]} * {16'd0, env_f};
    lo_p    = {33'd0, env_eff[31:0]} * {32'd0, env_f};
    env_sum = hi_p + {16'd0, lo_p[64:32]};
    env_nxt = env_sum[47:0];
  end

  assign lfsr_nxt = lfsr16(lfsr_r);

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      chirp_r <= RST_CHIRP_START;
      env_r   <= {1'b0, RST_ENV_START, 32'd0};
      done_r  <= '0;
      lfsr_r  <= LFSR_SEED;
    end else if (acc) begin
      if (produce) begin
        phase_r <= phase_nxt;
        chirp_r <= chirp_nxt;
        env_r   <= env_nxt;
        done_r  <= done_nxt;
        lfsr_r  <= lfsr_nxt;
      end else begin
        phase_r <= phase_eff;
        chirp_r <= chirp_eff;
        env_r   <= env_eff;
        done_r  <= done_eff;
      end
    end
  end

  // snapshot for the sample pipeline
  assign phase         = phase_eff;
  assign item.last     = done_nxt == limit;
  assign item.envelope = env_eff;
  assign item.noise_u  = lfsr_nxt[15:0];

`ifndef ASSERT_OFF
  // the final sample leaves the count at the limit
  a_last_count: assert property (@(posedge clk) disable iff (!rst_n)
    acc && produce && item.last |=> done_r == $past(limit))
    else $error("count not at limit after final sample");

  // a stopped item without restart leaves time where it was
  a_stop_hold: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !produce && !restart |=> phase_r == $past(phase_r) && done_r == $past(done_r))
    else $error("stopped generator moved its state");
`endif

endmodule

>>> sv/dctg_synth.sv
// ----------------------------------------------------------------------------
// dctg_synth
// Sample pipeline: table index and quadrant, quarter-wave sine ROM, envelope
// multiply, noise scaling, truncation toward zero and saturation.
// ----------------------------------------------------------------------------
module dctg_synth import dctg_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH,
  parameter int PHASE_BITS       = DEF_PHASE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic                  in_v,
  input  logic [PHASE_BITS-1:0] phase,
  input  dctg_item_t            item,
  input  logic [15:0]           noise_span,
  output logic                  res_v,
  output dctg_res_t             res
);

  localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH);
  localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PROD_W = PHASE_BITS + ADDR_W;
  localparam int Q4_W   = IDX_W + 2;

  localparam logic [Q4_W-1:0] DEP1 = Q4_W'(SINE_TABLE_DEPTH);
  localparam logic [Q4_W-1:0] DEP2 = Q4_W'(2 * SINE_TABLE_DEPTH);
  localparam logic [Q4_W-1:0] DEP3 = Q4_W'(3 * SINE_TABLE_DEPTH);

  // quarter-wave table, worked out at elaboration by the Taylor series
  logic [15:0] rom_w [0:SINE_TABLE_DEPTH];

  for (genvar i = 0; i <= SINE_TABLE_DEPTH; i++) begin : g_rom
    localparam logic [63:0] X  = (64'(i) * HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
    localparam logic [63:0] X2 = (X * X) >> 30;
    localparam logic [63:0] T1 = ((X * X2) >> 30) / 64'd6;
    localparam logic [63:0] T2 = ((T1 * X2) >> 30) / 64'd20;
    localparam logic [63:0] T3 = ((T2 * X2) >> 30) / 64'd42;
    localparam logic [63:0] T4 = ((T3 * X2) >> 30) / 64'd72;
    localparam logic [63:0] T5 = ((T4 * X2) >> 30) / 64'd110;
    localparam logic signed [63:0] SUM = $signed(X) - $signed(T1) + $signed(T2)
                                       - $signed(T3) + $signed(T4) - $signed(T5);
    localparam logic [63:0] POS = (SUM < 0) ? 64'd0 : 64'(SUM);
    localparam logic [63:0] RND = (POS + 64'd16384) >> 15;
    localparam logic [15:0] QV  = (RND > 64'd32768) ? 16'h8000 : RND[15:0];
    assign rom_w[i] = QV;
  end

  logic                  v1_r, v2_r, v3_r, v4_r;
  logic [PHASE_BITS-1:0] phase1_r;
  dctg_item_t            item1_r, item2_r;
  logic [ADDR_W-1:0]     addr2_r;
  logic                  neg2_r, neg3_r, neg4_r;
  logic [15:0]           rom3_r;
  logic [47:0]           env3_r;
  logic                  last3_r, last4_r;
  logic [33:0]           noise3_r, noise4_r;
  logic [31:0]           m4_r;

  logic [PROD_W-1:0]     idx_prod;
  logic [IDX_W-1:0]      idx;
  logic [Q4_W-1:0]       idx4, rem;
  logic [1:0]            quad;
  logic [ADDR_W-1:0]     addr;
  logic [31:0]           np;
  logic [33:0]           noise;
  logic [63:0]           eprod;
  logic [34:0]           sm, total, tmag;
  logic [18:0]           sh;
  logic                  tneg;
  logic [15:0]           sample;

  // table index, quadrant and mirrored address
  always_comb begin
    idx_prod = PROD_W'(phase1_r) * PROD_W'(SINE_TABLE_DEPTH);
    idx      = idx_prod[PHASE_BITS +: IDX_W];
    idx4     = {idx, 2'b00};
    if (idx4 >= DEP3) begin
      quad = 2'd3;
      rem  = idx4 - DEP3;
    end else if (idx4 >= DEP2) begin
      quad = 2'd2;
      rem  = idx4 - DEP2;
    end else if (idx4 >= DEP1) begin
      quad = 2'd1;
      rem  = idx4 - DEP1;
    end else begin
      quad = 2'd0;
      rem  = idx4;
    end
    addr = quad[0] ? ADDR_W'(DEP1 - rem) : ADDR_W'(rem);
  end

  // uniform noise centered on zero, in 1/65536 counts
  always_comb begin
    np    = {16'd0, item2_r.noise_u} * {16'd0, noise_span};
    noise = {2'b00, np} - {3'b000, noise_span, 15'd0};
  end

  // envelope times sine magnitude
  always_comb begin
    eprod = {16'd0, env3_r} * {48'd0, rom3_r};
  end

  // sign, noise, truncate toward zero, saturate
  always_comb begin
    sm   = neg4_r ? (35'd0 - {3'b000, m4_r}) : {3'b000, m4_r};
    total = sm + {noise4_r[33], noise4_r};
    tneg = total[34];
    tmag = tneg ? (35'd0 - total) : total;
    sh   = tmag[34:16];
    if (!tneg) begin
      sample = (sh > 19'd32767) ? 16'h7FFF : sh[15:0];
    end else begin
      sample = (sh > 19'd32768) ? 16'h8000 : (16'd0 - sh[15:0]);
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // stage payload, rom read registered in stage three
  always_ff @(posedge clk) begin
    if (adv) begin
      phase1_r <= phase;
      item1_r  <= item;
      addr2_r  <= addr;
      neg2_r   <= quad[1];
      item2_r  <= item1_r;
      rom3_r   <= rom_w[addr2_r];
      neg3_r   <= neg2_r;
      env3_r   <= item2_r.envelope;
      last3_r  <= item2_r.last;
      noise3_r <= noise;
      m4_r     <= eprod[62:31];
      neg4_r   <= neg3_r;
      noise4_r <= noise3_r;
      last4_r  <= last3_r;
    end
  end

  assign res_v      = v4_r;
  assign res.last   = last4_r;
  assign res.sample = sample;

endmodule

>>> sv/dctg_out.sv
// ----------------------------------------------------------------------------
// dctg_out
// Output register with a one-entry skid stage; the pipeline advances while
// the skid stage is empty.
// ----------------------------------------------------------------------------
module dctg_out import dctg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        res_v,
  input  dctg_res_t   res,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [15:0] out_sample,
  output logic        out_last,
  output logic        adv
);

  logic      out_valid_r, skid_v_r;
  dctg_res_t out_res_r, skid_res_r;
  logic      arrive, free;

  assign adv    = !skid_v_r;
  assign arrive = adv && res_v;
  assign free   = !out_valid_r || out_ready;

  // occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else if (free) begin
      out_valid_r <= skid_v_r || arrive;
      skid_v_r    <= 1'b0;
    end else if (arrive) begin
      skid_v_r <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (free) begin
      out_res_r <= skid_v_r ? skid_res_r : res;
    end
    if (!free && arrive) begin
      skid_res_r <= res;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_res_r.sample;
  assign out_last   = out_res_r.last;

`ifndef ASSERT_OFF
  // the skid stage only holds data behind a full output register
  a_skid_behind: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_valid_r)
    else $error("skid stage full while output register empty");

  // the skid stage fills only when the output stalls
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_valid_r && !out_ready))
    else $error("skid stage filled without a stall");
`endif

endmodule

>>> sv/decaying_chirp_tone_generator.sv
// ----------------------------------------------------------------------------
// decaying_chirp_tone_generator
// Damped sine source with a relaxing chirp and added LFSR noise.
// ----------------------------------------------------------------------------
// Each transfer on the in_ channel asks for one sample; in_restart set first
// returns phase, chirp, envelope and count to time zero. Each request that
// finds the count below point_count gives one transfer on the out_ channel
// (out_sample, out_last on the final one); a request past the end gives none
// and leaves the state as it is, apart from a restart.
// A sample is registered after the state loop, the index, the sine ROM read,
// the envelope multiply and in the output register, in that order.
// Throughput: one sample per cycle while in_ready is high, set by the state
// loop (phase add, 32x33 chirp decay, 48x33 envelope decay).
// When the receiver stalls, the output register holds its sample and one
// more is caught in a skid stage; in_ready drops while that stage is full
// and rises again in the cycle after the next output transfer.
// cfg_we writes register cfg_index with cfg_wdata at the clock edge; the
// user is to write registers only while the block is idle, which the block
// itself does not enforce. Start values take effect at the next restart.
// Reset (synchronous, rst_n low) loads register defaults, time zero and the
// LFSR seed, and empties the pipeline.
// ----------------------------------------------------------------------------
module decaying_chirp_tone_generator import dctg_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH,
  parameter int PHASE_BITS       = DEF_PHASE_BITS,
  parameter int COUNT_BITS       = DEF_COUNT_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_restart,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [15:0]    out_sample,
  output logic                  out_last,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [31:0] base_step_r;
  logic [31:0] chirp_start_r;
  logic [32:0] chirp_decay_r;
  logic [14:0] env_start_r;
  logic [32:0] env_decay_r;
  logic [15:0] noise_span_r;
  logic [23:0] point_count_r;

  logic [32:0]           chirp_f, env_f;
  logic                  adv, acc, produce, res_v;
  logic [PHASE_BITS-1:0] phase;
  dctg_item_t            item;
  dctg_res_t             res;
  logic [15:0]           sample;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_step_r   <= RST_BASE_STEP;
      chirp_start_r <= RST_CHIRP_START;
      chirp_decay_r <= RST_CHIRP_DECAY;
      env_start_r   <= RST_ENV_START;
      env_decay_r   <= RST_ENV_DECAY;
      noise_span_r  <= RST_NOISE_SPAN;
      point_count_r <= RST_POINT_COUNT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASE_STEP:   base_step_r   <= cfg_wdata[31:0];
        REG_CHIRP_START: chirp_start_r <= cfg_wdata[31:0];
        REG_CHIRP_DECAY: chirp_decay_r <= cfg_wdata[32:0];
        REG_ENV_START:   env_start_r   <= cfg_wdata[14:0];
        REG_ENV_DECAY:   env_decay_r   <= cfg_wdata[32:0];
        REG_NOISE_SPAN:  noise_span_r  <= cfg_wdata[15:0];
        REG_POINT_COUNT: point_count_r <= cfg_wdata[23:0];
        default: ;
      endcase
    end
  end

  // decay factors above unity are held at unity
  assign chirp_f = (chirp_decay_r > ONE_Q32) ? ONE_Q32 : chirp_decay_r;
  assign env_f   = (env_decay_r > ONE_Q32) ? ONE_Q32 : env_decay_r;

  assign in_ready = adv;
  assign acc      = in_valid && adv;

  dctg_state #(
    .PHASE_BITS (PHASE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_state (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .restart     (in_restart),
    .base_step   (base_step_r),
    .chirp_start (chirp_start_r),
    .chirp_f     (chirp_f),
    .env_start   (env_start_r),
    .env_f       (env_f),
    .point_count (point_count_r),
    .produce     (produce),
    .phase       (phase),
    .item        (item)
  );

  dctg_synth #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .PHASE_BITS       (PHASE_BITS)
  ) u_synth (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_v       (acc && produce),
    .phase      (phase),
    .item       (item),
    .noise_span (noise_span_r),
    .res_v      (res_v),
    .res        (res)
  );

  dctg_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_v      (res_v),
    .res        (res),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .out_sample (sample),
    .out_last   (out_last),
    .adv        (adv)
  );

  assign out_sample = sample;

endmodule

>>> tb/dctg_sample_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dctg_sample_check
// Watches the request, sample and register ports of the tone generator,
// keeps its own copy of the generator state, predicts every sample and
// compares each sample transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module dctg_sample_check import dctg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  in_restart,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic signed [15:0]    out_sample,
  input  logic                  out_last,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    mismatch_count,
  output int                    samples_pending
);

  localparam logic [63:0] COUNT_MAX  = (64'd1 << DEF_COUNT_BITS) - 64'd1;
  localparam logic [63:0] TABLE_SIZE = 64'(DEF_SINE_TABLE_DEPTH);
  localparam int          MAX_SHOWN  = 10;

  // register shadows
  logic [31:0] base_step_r;
  logic [31:0] chirp_start_r;
  logic [32:0] chirp_decay_r;
  logic [14:0] env_start_r;
  logic [32:0] env_decay_r;
  logic [15:0] noise_span_r;
  logic [23:0] point_count_r;

  // generator state
  logic [31:0] phase_q;
  logic [31:0] chirp_q;
  logic [47:0] env_q;
  logic [23:0] done_q;
  logic [31:0] lfsr_q;

  // predicted samples not yet seen at the output
  dctg_res_t tone_queue[$];

  // quarter-wave magnitude in Q1.15 from a Taylor series on Q2.30 angle
  function automatic logic [15:0] quarter_wave(input logic [63:0] r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] rounded;
    longint      acc;
    int          n;
    x    = (r * HALF_PI_Q30) / TABLE_SIZE;
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (n = 1; n <= 5; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc -= longint'(term);
      end else begin
        acc += longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    rounded = (64'(acc) + 64'd16384) >> 15;
    return (rounded > 64'd32768) ? 16'd32768 : rounded[15:0];
  endfunction

  // back to time zero from the start registers
  function automatic void rewind_tone();
    phase_q = '0;
    chirp_q = chirp_start_r;
    env_q   = {1'b0, env_start_r, 32'd0};
    done_q  = '0;
  endfunction

  // one request: returns 1 and the sample when generation is still running
  function automatic bit next_tone_sample(input logic restart, output dctg_res_t res);
    logic [63:0] limit;
    logic [63:0] idx;
    logic [63:0] quad;
    logic [63:0] rem;
    logic [63:0] qmag;
    logic [63:0] mag;
    logic [63:0] u;
    logic [63:0] env_next;
    logic [32:0] f;
    logic [31:0] cneg;
    logic [64:0] cprod;
    longint      noise;
    longint      total;
    int          k;
    bit          lsb;
    res = '0;
    if (restart) begin
      rewind_tone();
    end
    limit = (64'(point_count_r) < COUNT_MAX) ? 64'(point_count_r) : COUNT_MAX;
    if (64'(done_q) >= limit) begin
      return 1'b0;
    end

    // sine magnitude from quadrant and remainder of the table index
    idx  = (64'(phase_q) * TABLE_SIZE) >> 32;
    quad = (64'd4 * idx) / TABLE_SIZE;
    rem  = 64'd4 * idx - quad * TABLE_SIZE;
    quad = quad & 64'd3;
    qmag = 64'(quarter_wave(quad[0] ? TABLE_SIZE - rem : rem));
    mag  = (64'(env_q) * qmag) >> 31;

    // noise from sixteen lfsr steps
    for (k = 0; k < 16; k++) begin
      lsb    = lfsr_q[0];
      lfsr_q = lfsr_q >> 1;
      if (lsb) begin
        lfsr_q = lfsr_q ^ LFSR_MASK;
      end
    end
    u     = 64'(lfsr_q[15:0]);
    noise = longint'(u) * longint'(noise_span_r) - longint'(noise_span_r) * 32768;

    // sum, truncate toward zero, saturate
    total = ((quad >= 64'd2) ? -longint'(mag) : longint'(mag)) + noise;
    total = total / 65536;
    if (total > 32767) begin
      total = 32767;
    end
    if (total < -32768) begin
      total = -32768;
    end
    res.sample = total[15:0];
    res.last   = (64'(done_q) + 64'd1 == limit);

    // advance phase
    phase_q = phase_q + (base_step_r + chirp_q);

    // chirp decays toward zero, sign kept
    f = (chirp_decay_r > ONE_Q32) ? ONE_Q32 : chirp_decay_r;
    if (chirp_q[31]) begin
      cneg    = 32'd0 - chirp_q;
      cprod   = (65'(cneg) * 65'(f)) >> 32;
      chirp_q = 32'd0 - cprod[31:0];
    end else begin
      cprod   = (65'(chirp_q) * 65'(f)) >> 32;
      chirp_q = cprod[31:0];
    end

    // envelope decay in two halves
    f        = (env_decay_r > ONE_Q32) ? ONE_Q32 : env_decay_r;
    env_next = 64'(env_q[47:32]) * 64'(f) + ((64'(env_q[31:0]) * 64'(f)) >> 32);
    env_q    = env_next[47:0];

    done_q = done_q + 24'd1;
    return 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    dctg_res_t want;
    if (!rst_n) begin
      base_step_r   = RST_BASE_STEP;
      chirp_start_r = RST_CHIRP_START;
      chirp_decay_r = RST_CHIRP_DECAY;
      env_start_r   = RST_ENV_START;
      env_decay_r   = RST_ENV_DECAY;
      noise_span_r  = RST_NOISE_SPAN;
      point_count_r = RST_POINT_COUNT;
      lfsr_q        = LFSR_SEED;
      rewind_tone();
      tone_queue.delete();
    end else begin
      // request transfer
      if (in_valid && in_ready) begin
        if (next_tone_sample(in_restart, want)) begin
          tone_queue.push_back(want);
        end
      end

      // sample transfer
      if (out_valid && out_ready) begin
        if (tone_queue.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_SHOWN) begin
            $display("[%0t] unexpected sample %0d last %0b", $realtime, out_sample,
                     out_last);
          end
        end else begin
          want = tone_queue.pop_front();
          if (out_sample !== want.sample) begin
            mismatch_count++;
            if (mismatch_count <= MAX_SHOWN) begin
              $display("[%0t] sample: expected %0d, got %0d", $realtime,
                       $signed(want.sample), out_sample);
            end
          end
          if (out_last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= MAX_SHOWN) begin
              $display("[%0t] last flag: expected %0b, got %0b", $realtime, want.last,
                       out_last);
            end
          end
        end
      end

      // register write, after the request of the same edge
      if (cfg_we) begin
        case (cfg_index)
          REG_BASE_STEP:   base_step_r   = cfg_wdata[31:0];
          REG_CHIRP_START: chirp_start_r = cfg_wdata[31:0];
          REG_CHIRP_DECAY: chirp_decay_r = cfg_wdata[32:0];
          REG_ENV_START:   env_start_r   = cfg_wdata[14:0];
          REG_ENV_DECAY:   env_decay_r   = cfg_wdata[32:0];
          REG_NOISE_SPAN:  noise_span_r  = cfg_wdata[15:0];
          REG_POINT_COUNT: point_count_r = cfg_wdata[23:0];
          default: ;
        endcase
      end
    end
    samples_pending = tone_queue.size();
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives requests and register writes into the decaying chirp tone
// generator with random gaps and output stalls; a directed opening covers
// quarter-turn phases, saturation, the end of the point count and restarts,
// then random register settings and request streams follow.
// ----------------------------------------------------------------------------
module tb;
  import dctg_pkg::*;

  localparam int RUN_LIMIT    = 400000;
  localparam int RANDOM_REQS  = 650;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES  = 90;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_restart;
  logic                  out_valid;
  logic                  out_ready;
  logic signed [15:0]    out_sample;
  logic                  out_last;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int mismatch_count;
  int samples_pending;
  int cycle_count;
  int requests_sent;
  bit no_idle;

  decaying_chirp_tone_generator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_restart (in_restart),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_sample (out_sample),
    .out_last   (out_last),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  dctg_sample_check u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_restart      (in_restart),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sample      (out_sample),
    .out_last        (out_last),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .mismatch_count  (mismatch_count),
    .samples_pending (samples_pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  function automatic int idle_cycles();
    return no_idle ? 0 : $urandom_range(0, 14);
  endfunction

  // decay factor: realistic, exactly one, above one or anything
  function automatic logic [32:0] rand_factor();
    case ($urandom_range(0, 4))
      0: return {1'($urandom_range(0, 1)), 32'($urandom)};
      1: return ONE_Q32 - 33'($urandom_range(0, 32'h0040_0000));
      2: return ONE_Q32;
      3: return 33'h1_FFFF_FFFF;
      default: return 33'($urandom);
    endcase
  endfunction

  // register write, one cycle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // one request transfer after a random gap
  task automatic send_req(input logic restart);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
  endtask

  // stop requesting and let every predicted sample come out
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (samples_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // sample receiver with random stalls and an occasional long hold-off
  initial begin : receiver
    int stall;
    int taken;
    out_ready = 1'b0;
    taken     = 0;
    wait (rst_n === 1'b1);
    forever begin
      stall = (taken % 200 == 100) ? HOLD_CYCLES : idle_cycles();
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      taken++;
    end
  end

  initial begin : stimulus
    int          n;
    int          i;
    int          draw;
    int          target;
    logic [32:0] val;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_restart    = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = REG_BASE_STEP;
    cfg_wdata     = '0;
    no_idle       = 1'b0;
    requests_sent = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // register defaults straight out of reset
    send_req(1'b0);
    send_req(1'b0);
    send_req(1'b1);
    send_req(1'b0);
    settle();

    // exact quarter turns at full amplitude, no decay
    write_reg(REG_BASE_STEP, 33'h0_4000_0000);
    write_reg(REG_ENV_START, 33'd32767);
    write_reg(REG_ENV_DECAY, ONE_Q32);
    send_req(1'b1);
    repeat (4) send_req(1'b0);
    settle();

    // noise beyond half scale, factors above one, most negative chirp,
    // count of three reached, then restart after stop
    write_reg(REG_NOISE_SPAN, 33'h0_0000_FFFF);
    write_reg(REG_CHIRP_START, 33'h0_8000_0000);
    write_reg(REG_CHIRP_DECAY, 33'h1_FFFF_FFFF);
    write_reg(REG_ENV_DECAY, 33'h1_FFFF_FFFF);
    write_reg(REG_BASE_STEP, 33'h0_FFFF_FFFF);
    write_reg(REG_POINT_COUNT, 33'd3);
    send_req(1'b1);
    repeat (4) send_req(1'b0);
    send_req(1'b1);
    send_req(1'b0);
    settle();

    // start values changed mid-run only count after the next restart
    write_reg(REG_ENV_START, '0);
    write_reg(REG_CHIRP_START, 33'h0_7FFF_FFFF);
    write_reg(REG_CHIRP_DECAY, '0);
    write_reg(REG_ENV_DECAY, '0);
    write_reg(REG_NOISE_SPAN, 33'd32768);
    write_reg(REG_POINT_COUNT, 33'h0_00FF_FFFF);
    send_req(1'b0);
    send_req(1'b1);
    send_req(1'b0);
    settle();

    // zero point count gives nothing
    write_reg(REG_POINT_COUNT, '0);
    send_req(1'b1);
    send_req(1'b0);
    settle();

    // random settings and request streams
    target = requests_sent + RANDOM_REQS;
    while (requests_sent < target) begin
      draw = $urandom_range(0, 3);
      if (draw == 0) val = 33'($urandom);
      else if (draw == 1) val = 33'($urandom_range(0, 32'h00FF_FFFF));
      else if (draw == 2) val = 33'h0_FFFF_FFFF;
      else val = '0;
      write_reg(REG_BASE_STEP, val);

      draw = $urandom_range(0, 4);
      if (draw == 0) val = 33'($urandom);
      else if (draw == 1) val = 33'(32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000);
      else if (draw == 2) val = 33'h0_8000_0000;
      else if (draw == 3) val = 33'h0_7FFF_FFFF;
      else val = '0;
      write_reg(REG_CHIRP_START, val);

      write_reg(REG_CHIRP_DECAY, rand_factor());
      write_reg(REG_ENV_DECAY, rand_factor());

      draw = $urandom_range(0, 3);
      if (draw == 0) val = 33'd32767;
      else if (draw == 1) val = '0;
      else val = 33'($urandom_range(0, 32767));
      write_reg(REG_ENV_START, val);

      draw = $urandom_range(0, 5);
      if (draw <= 1) val = '0;
      else if (draw == 2) val = 33'($urandom_range(0, 200));
      else if (draw == 3) val = 33'd32768;
      else val = 33'($urandom_range(0, 65535));
      write_reg(REG_NOISE_SPAN, val);

      draw = $urandom_range(0, 15);
      if (draw == 0) val = '0;
      else if (draw <= 4) val = 33'($urandom_range(1, 40));
      else if (draw <= 10) val = 33'($urandom_range(41, 4000));
      else if (draw <= 13) val = 33'($urandom_range(0, 32'h00FF_FFFF));
      else val = 33'h0_00FF_FFFF;
      write_reg(REG_POINT_COUNT, val);

      // a quarter of the streams run with no gaps or random stalls, apart from the long hold-off
      no_idle = ($urandom_range(0, 3) == 0);
      n = $urandom_range(20, 90);
      for (i = 0; i < n; i++) begin
        send_req((i == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 24) == 0));
      end
      settle();
    end

    if (mismatch_count == 0 && samples_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
